// File: sv/ias_pkg.sv
// ----------------------------------------------------------------------------
// Insertion sort array package
// Shared types for the sorting cells and the top level.
// ----------------------------------------------------------------------------
package ias_pkg;

    // Width of one sorted value.
    localparam int unsigned VALUE_W = 32;

    typedef logic signed [VALUE_W-1:0] value_t;

    // What one cell shows to its neighbors.
    typedef struct packed {
        logic   valid;  // cell holds a value
        logic   gt;     // held value is greater than the value being inserted
        value_t value;  // held value
    } link_t;

endpackage

// File: sv/insertion_sort_array.sv
// ----------------------------------------------------------------------------
// Insertion sort array
// Stable streaming sort of signed 32-bit values in a chain of cells.
// ----------------------------------------------------------------------------
// While loading, the block takes one item per cycle: every cell compares its
// value with the new one at the same time and the chain opens a gap in one
// step. After the item marked last_in, the input stalls while the chain
// drains through slot zero into the output register. One value moves per
// cycle in which the output register is empty or its item is taken, and the
// input stays stalled until every stored value of the run has moved, so
// output stalls lengthen the stall. The next run starts in the cycle after
// the last value enters the output register. At most DEPTH values are kept;
// later ones are dropped and overflow is set on every result of that run.
module insertion_sort_array
    import ias_pkg::*;
#(
    parameter int unsigned DEPTH = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [31:0]   value,
    input  logic          last_in,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [31:0]   sorted_value,
    output logic          last_out,
    output logic          overflow
);

    logic   drain_reg;
    logic   dropped_reg;
    logic   out_valid_reg;
    value_t sorted_value_reg;
    logic   last_out_reg;
    logic   overflow_reg;

    logic   accept;
    logic   full;
    logic   insert;
    logic   pop;
    value_t new_value;

    link_t  links [DEPTH];
    link_t  left_links [DEPTH];
    link_t  right_links [DEPTH];

    assign new_value = value_t'(value);
    assign in_stall  = drain_reg;
    assign accept    = in_valid && !drain_reg;
    assign full      = links[DEPTH-1].valid;
    assign insert    = accept && !full;
    assign pop       = drain_reg && (!out_valid_reg || !out_stall);

    // Chain of cells with neighbor links.
    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                assign left_links[i] = '{valid: 1'b1, gt: 1'b0, value: new_value};
            end
            else
            begin : g_body
                assign left_links[i] = links[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign right_links[i] = '0;
            end
            else
            begin : g_mid
                assign right_links[i] = links[i+1];
            end

            ias_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .insert    (insert),
                .shift     (pop),
                .new_value (new_value),
                .left      (left_links[i]),
                .right     (right_links[i]),
                .link      (links[i])
            );
        end
    endgenerate

    // Run control and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg     <= 1'b0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (full)
                begin
                    dropped_reg <= 1'b1;
                end
                if (last_in)
                begin
                    drain_reg <= 1'b1;
                end
            end

            if (pop)
            begin
                out_valid_reg <= 1'b1;
                if (!links[1].valid)
                begin
                    drain_reg   <= 1'b0;
                    dropped_reg <= 1'b0;
                end
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            sorted_value_reg <= links[0].value;
            last_out_reg     <= !links[1].valid;
            overflow_reg     <= dropped_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sorted_value = 32'(sorted_value_reg);
    assign last_out     = last_out_reg;
    assign overflow     = overflow_reg;

endmodule

// File: sv/ias_cell.sv
// ----------------------------------------------------------------------------
// Insertion sort cell
// One slot of the sorting chain. It keeps its value, takes the value of its
// left neighbor or the new value on an insert, and takes the value of its
// right neighbor when the chain drains toward slot zero.
// ----------------------------------------------------------------------------
module ias_cell
    import ias_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   insert,
    input  logic   shift,
    input  value_t new_value,
    input  link_t  left,
    input  link_t  right,
    output link_t  link
);

    logic   valid_reg;
    logic   valid_next;
    value_t value_reg;
    value_t value_next;
    logic   gt;

    // Signed compare: the new value goes after every equal value.
    assign gt = valid_reg && (value_reg > new_value);

    assign link.valid = valid_reg;
    assign link.gt    = gt;
    assign link.value = value_reg;

    // Next slot contents.
    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        if (shift)
        begin
            valid_next = right.valid;
            value_next = right.value;
        end
        else if (insert)
        begin
            if (gt || (!valid_reg && left.valid))
            begin
                valid_next = 1'b1;
                value_next = left.gt ? left.value : new_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// File: verif/insertion_sort_array_test.sv
// ----------------------------------------------------------------------------
// Insertion sort array testbench
// Streams runs of signed values into the sorter and checks every emitted item
// against a sorted shadow copy kept by the bench, with random input bursts
// and output stalls.
// ----------------------------------------------------------------------------
module insertion_sort_array_test;

    import ias_pkg::*;

    localparam int unsigned SORT_DEPTH   = 64;
    localparam int          RANDOM_ITEMS = 400;
    localparam int          IDLE_LIMIT   = 2000;
    localparam int          SETTLE_TIME  = SORT_DEPTH + 20;

    // One item on the input side.
    typedef struct packed {
        value_t value;
        logic   mark;
    } sort_item_t;

    // One item expected on the output side.
    typedef struct packed {
        value_t value;
        logic   last;
        logic   ovf;
    } sorted_result_t;

    logic          clk          = 1'b0;
    logic          rst_n        = 1'b0;
    logic          in_valid     = 1'b0;
    logic          in_stall;
    logic [31:0]   value        = '0;
    logic          last_in      = 1'b0;
    logic          out_valid;
    logic          out_stall    = 1'b0;
    logic [31:0]   sorted_value;
    logic          last_out;
    logic          overflow;

    sort_item_t     items_to_send[$];
    sorted_result_t expected_sorted[$];

    // Shadow copy of the sorter contents.
    value_t held_values[SORT_DEPTH];
    int     held_count     = 0;
    logic   values_dropped = 1'b0;

    int items_total    = 0;
    int items_accepted = 0;
    int results_seen   = 0;
    int mismatches     = 0;

    insertion_sort_array #(
        .DEPTH(SORT_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .value(value),
        .last_in(last_in),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sorted_value(sorted_value),
        .last_out(last_out),
        .overflow(overflow)
    );

    always #6 clk = ~clk;

    // Insert one accepted value into the shadow copy; a marked item releases
    // the whole sorted run into the expected queue.
    function automatic void absorb_item(input value_t v, input logic mark);
        int pos;
        sorted_result_t r;
        if (held_count >= SORT_DEPTH)
        begin
            values_dropped = 1'b1;
        end
        else
        begin
            pos = 0;
            // Equal values stay in arrival order.
            while (pos < held_count && held_values[pos] <= v)
                pos++;
            for (int k = held_count; k > pos; k--)
                held_values[k] = held_values[k - 1];
            held_values[pos] = v;
            held_count++;
        end
        if (mark)
        begin
            for (int k = 0; k < held_count; k++)
            begin
                r.value = held_values[k];
                r.last  = (k == held_count - 1);
                r.ovf   = values_dropped;
                expected_sorted.push_back(r);
            end
            held_count     = 0;
            values_dropped = 1'b0;
        end
    endfunction

    // Values lean toward the extremes and toward small numbers so that
    // duplicates are common.
    function automatic value_t pick_value();
        value_t v;
        case ($urandom_range(0, 9))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7fff_ffff;
            2, 3:    v = value_t'(int'($urandom_range(0, 8)) - 4);
            default: v = value_t'($urandom);
        endcase
        return v;
    endfunction

    function automatic void queue_item(input value_t v, input logic mark);
        sort_item_t it;
        it.value = v;
        it.mark  = mark;
        items_to_send.push_back(it);
    endfunction

    // A run of random values whose final item is marked.
    function automatic void queue_run(input int len);
        for (int k = 0; k < len; k++)
            queue_item(pick_value(), k == len - 1);
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("mismatch on result %0d: %s", results_seen, what);
    endtask

    // Stimulus, reset and end of run.
    initial
    begin
        int random_items;
        int len;

        // Lone minimum and lone maximum.
        queue_item(32'h8000_0000, 1'b1);
        queue_item(32'h7fff_ffff, 1'b1);
        // Mixed signs, extremes and equal values.
        queue_item(3, 1'b0);
        queue_item(-3, 1'b0);
        queue_item(32'h7fff_ffff, 1'b0);
        queue_item(32'h8000_0000, 1'b0);
        queue_item(-1, 1'b0);
        queue_item(0, 1'b0);
        queue_item(1, 1'b0);
        queue_item(3, 1'b0);
        queue_item(3, 1'b0);
        queue_item(-3, 1'b0);
        queue_item(0, 1'b1);
        // All values equal.
        queue_item(5, 1'b0);
        queue_item(5, 1'b0);
        queue_item(5, 1'b1);
        // Strictly descending input.
        queue_item(100, 1'b0);
        queue_item(50, 1'b0);
        queue_item(-50, 1'b0);
        queue_item(-100, 1'b1);

        // A run that fills the store exactly, then one that overflows and
        // whose marked item is itself dropped.
        random_items = 2 * SORT_DEPTH + 3;
        queue_run(SORT_DEPTH);
        queue_run(SORT_DEPTH + 3);
        // Mostly short runs, some medium, a few around the store depth.
        while (random_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 19))
                0:       len = $urandom_range(SORT_DEPTH - 4, SORT_DEPTH + 6);
                1, 2, 3: len = $urandom_range(9, 30);
                default: len = $urandom_range(1, 8);
            endcase
            queue_run(len);
            random_items += len;
        end
        items_total = items_to_send.size();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (items_accepted < items_total)
            @(posedge clk);
        while (expected_sorted.size() > 0)
            @(posedge clk);
        repeat (SETTLE_TIME) @(posedge clk);

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Input driver: bursts of items separated by random gaps.
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk)
    begin
        sort_item_t next_item;
        if (rst_n)
        begin
            if (in_valid && in_stall === 1'b0)
            begin
                absorb_item(value, last_in);
                items_accepted++;
            end

            // A stalled item is held unchanged.
            if (!in_valid || in_stall === 1'b0)
            begin
                if (burst_left > 0 && items_to_send.size() > 0)
                begin
                    next_item = items_to_send.pop_front();
                    in_valid  <= 1'b1;
                    value     <= next_item.value;
                    last_in   <= next_item.mark;
                    burst_left--;
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (gap_left > 0)
                    begin
                        gap_left--;
                    end
                    else if ($urandom_range(0, 4) == 0)
                    begin
                        // Long stretch with no gaps at all.
                        burst_left = $urandom_range(50, 150);
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = $urandom_range(0, 12);
                    end
                end
            end
        end
    end

    // Output stall pattern: free running, random, periodic or heavy, with the
    // mode changing every so often.
    int stall_mode      = 0;
    int stall_mode_left = 0;
    int stall_period    = 2;
    int stall_phase     = 0;

    always @(posedge clk)
    begin
        if (stall_mode_left == 0)
        begin
            stall_mode      = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(20, 200);
            stall_period    = $urandom_range(2, 9);
        end
        else
        begin
            stall_mode_left--;
        end
        stall_phase++;
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ((stall_phase % stall_period) < stall_period / 2);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Output checker.
    always @(posedge clk)
    begin
        sorted_result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_sorted.size() == 0)
            begin
                report_mismatch($sformatf("unexpected item, value %0d",
                                          $signed(sorted_value)));
            end
            else
            begin
                want = expected_sorted.pop_front();
                if (sorted_value !== want.value)
                    report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                              $signed(sorted_value), want.value));
                if (last_out !== want.last)
                    report_mismatch($sformatf("last_out %b, expected %b",
                                              last_out, want.last));
                if (overflow !== want.ovf)
                    report_mismatch($sformatf("overflow %b, expected %b",
                                              overflow, want.ovf));
            end
            results_seen++;
        end
    end

    // Watchdog on cycles in which neither side moves an item.
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

endmodule
